### rtl/vwts_pkg.sv
// vwts_pkg: shared types, constants and helpers for the vertex projection block.
// No dependencies; used by every file under rtl/.
package vwts_pkg;

    localparam int FRAC_BITS_DEF = 16;   // default fraction bits of the fixed-point format
    localparam int QUO_BITS      = 40;   // quotient magnitude is clamped to 2^QUO_BITS
    localparam int QUEUE_DEPTH   = 4;    // request queue between front and back
    localparam int DIM_W         = 15;   // screen width/height register width
    localparam int IN_DATA_W     = 136;  // 4 + 4*32 bits, padded to bytes
    localparam int OUT_DATA_W    = 96;

    localparam logic [14:0] WIDTH_RESET  = 15'd1024;
    localparam logic [14:0] HEIGHT_RESET = 15'd768;

    // command codes (s_tuser)
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROJECT = 1'b1;

    // config register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // result status codes (m_tuser)
    localparam logic [1:0] ST_VISIBLE = 2'd0;
    localparam logic [1:0] ST_BEHIND  = 2'd1;
    localparam logic [1:0] ST_ZERO_W  = 2'd2;

    typedef struct packed {
        logic        is_load;
        logic [3:0]  idx;
        logic [31:0] val;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } vwts_item_t;

    // divider sideband: one per request in flight through the divider
    typedef struct packed {
        logic [1:0] status;
        logic [2:0] neg;
        logic [2:0] ovf;
    } vwts_side_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'h7fff_ffff;
        else if (v < -64'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

### rtl/vwts_front.sv
// vwts_front: input register stage; decodes stream requests into queue entries.
// Depends on vwts_pkg.
module vwts_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [vwts_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [0:0]                      s_tuser,
    output vwts_pkg::vwts_item_t            item,
    output logic                            item_valid,
    input  logic                            item_ready
);

    logic                 valid_reg;
    vwts_pkg::vwts_item_t item_reg;
    vwts_pkg::vwts_item_t item_next;

    always_comb
    begin
        item_next.is_load = (s_tuser[0] == vwts_pkg::CMD_LOAD);
        item_next.idx     = s_tdata[3:0];
        item_next.val     = s_tdata[35:4];
        item_next.x       = s_tdata[67:36];
        item_next.y       = s_tdata[99:68];
        item_next.z       = s_tdata[131:100];
    end

    assign s_tready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (s_tready)
            valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            item_reg <= item_next;
    end

endmodule

### rtl/vwts_fifo.sv
// vwts_fifo: short request queue decoupling the front from the back.
// Depends on vwts_pkg.
module vwts_fifo #(
    parameter int DEPTH = vwts_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  vwts_pkg::vwts_item_t push_item,
    output logic                 push_ready,
    output logic                 out_valid,
    output vwts_pkg::vwts_item_t out_item,
    input  logic                 pop
);

    localparam int AW = $clog2(DEPTH);

    vwts_pkg::vwts_item_t mem_reg [DEPTH];
    logic [AW-1:0]        wr_ptr_reg;
    logic [AW-1:0]        rd_ptr_reg;
    logic [AW:0]          count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != (AW+1)'(DEPTH));
    assign out_valid  = (count_reg != '0);
    assign out_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### rtl/vwts_div.sv
// vwts_div: pipelined restoring divider, one quotient bit per stage.
// Depends on vwts_pkg.
module vwts_div #(
    parameter int FRAC_BITS = vwts_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [2*32+2-FRAC_BITS-2:0]   den,
    input  logic [2*32+2-FRAC_BITS-2:0]   rem0,
    input  logic [vwts_pkg::QUO_BITS-1:0] num,
    output logic [vwts_pkg::QUO_BITS-1:0] quo
);

    localparam int CW = 2*32 + 2 - FRAC_BITS;
    localparam int QB = vwts_pkg::QUO_BITS;

    logic [CW-2:0] rem_s [QB+1];
    logic [CW-2:0] den_s [QB+1];
    logic [QB-1:0] num_s [QB+1];
    logic [QB-1:0] quo_s [QB+1];
    logic [CW-2:0] rem_reg [QB];
    logic [CW-2:0] den_reg [QB];
    logic [QB-1:0] num_reg [QB];
    logic [QB-1:0] quo_reg [QB];

    assign rem_s[0] = rem0;
    assign den_s[0] = den;
    assign num_s[0] = num;
    assign quo_s[0] = '0;
    assign quo      = quo_s[QB];

    for (genvar k = 0; k < QB; k++)
    begin : g_stage
        logic [CW-1:0] trial;
        logic [CW:0]   diff;
        logic          qbit;

        // shift in the next numerator bit, try to subtract the divisor
        assign trial = {rem_s[k], num_s[k][QB-1]};
        assign diff  = {1'b0, trial} - {2'b00, den_s[k]};
        assign qbit  = ~diff[CW];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= qbit ? diff[CW-2:0] : trial[CW-2:0];
                den_reg[k] <= den_s[k];
                num_reg[k] <= {num_s[k][QB-2:0], 1'b0};
                quo_reg[k] <= {quo_s[k][QB-2:0], qbit};
            end
        end

        assign rem_s[k+1] = rem_reg[k];
        assign den_s[k+1] = den_reg[k];
        assign num_s[k+1] = num_reg[k];
        assign quo_s[k+1] = quo_reg[k];
    end

endmodule

### rtl/vwts_back.sv
// vwts_back: view matrix store and projection pipeline (transform, divide, viewport).
// Depends on vwts_pkg and vwts_div.
module vwts_back #(
    parameter int FRAC_BITS = vwts_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  vwts_pkg::vwts_item_t       item,
    input  logic                       item_valid,
    output logic                       item_pop,
    input  logic [vwts_pkg::DIM_W-1:0] scr_width,
    input  logic [vwts_pkg::DIM_W-1:0] scr_height,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 out_status,
    output logic [31:0]                out_x,
    output logic [31:0]                out_y,
    output logic [31:0]                out_z
);

    localparam int QB = vwts_pkg::QUO_BITS;
    localparam int PW = 64 - FRAC_BITS;        // product after the fraction shift
    localparam int CW = 2*32 + 2 - FRAC_BITS;  // clip coordinate width
    localparam int SH = QB - FRAC_BITS;
    localparam int NW = QB + 2;                // signed normalized coordinate
    localparam int MW = NW + 1 + vwts_pkg::DIM_W + 1;
    localparam logic signed [NW:0] ONE = (NW+1)'(1) << FRAC_BITS;

    logic en;

    // matrix, column major; written in request order as loads leave the queue
    logic signed [31:0] mat_reg [16];

    // S1
    logic               v1_reg;
    logic signed [31:0] x1_reg, y1_reg, z1_reg;
    // S2
    logic               v2_reg;
    logic signed [PW-1:0] px2_reg [4];
    logic signed [PW-1:0] py2_reg [4];
    logic signed [PW-1:0] pz2_reg [4];
    logic signed [31:0]   t2_reg [4];
    logic signed [63:0]   mx [4];
    logic signed [63:0]   my [4];
    logic signed [63:0]   mz [4];
    // S3, S4
    logic               v3_reg, v4_reg;
    logic signed [CW-1:0] a3_reg [4];
    logic signed [CW-1:0] b3_reg [4];
    logic signed [CW-1:0] c4_reg [4];
    // S5
    logic               v5_reg;
    logic [1:0]         st5_reg;
    logic [2:0]         neg5_reg;
    logic [CW-1:0]      mag5_reg [3];
    logic [CW-2:0]      w5_reg;
    logic [1:0]         st5_next;
    // S6
    logic               v6_reg;
    logic [1:0]         st6_reg;
    logic [2:0]         neg6_reg;
    logic [2:0]         ovf6_reg;
    logic [CW-2:0]      rem6_reg [3];
    logic [QB-1:0]      num6_reg [3];
    logic [CW-2:0]      den6_reg;
    // divider
    logic [QB-1:0]         quo [3];
    vwts_pkg::vwts_side_t  sb_reg [QB];
    logic                  sbv_reg [QB];
    vwts_pkg::vwts_side_t  sb_last;
    // Q1..Q3
    logic               vq1_reg, vq2_reg, vq3_reg;
    logic [1:0]         sq1_reg, sq2_reg, sq3_reg;
    logic signed [NW-1:0] n1_reg [3];
    logic signed [NW-1:0] nz2_reg, nz3_reg;
    logic signed [NW:0]   ax2_reg, by2_reg;
    logic signed [MW-1:0] px3_reg, py3_reg;
    // output register
    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [31:0]        out_x_reg, out_y_reg, out_z_reg;

    // whole pipeline moves unless the output register holds an untaken result
    assign en       = !out_valid_reg || out_ready;
    assign item_pop = en && item_valid;

    always_ff @(posedge clk)
    begin
        if (item_pop && item.is_load)
            mat_reg[item.idx] <= item.val;
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            mx[r] = x1_reg * mat_reg[r];
            my[r] = y1_reg * mat_reg[4+r];
            mz[r] = z1_reg * mat_reg[8+r];
        end
    end

    always_comb
    begin
        if (c4_reg[3][CW-1])
            st5_next = vwts_pkg::ST_BEHIND;
        else if (c4_reg[3] == '0)
            st5_next = vwts_pkg::ST_ZERO_W;
        else
            st5_next = vwts_pkg::ST_VISIBLE;
    end

    assign sb_last = sb_reg[QB-1];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            for (int k = 0; k < QB; k++)
                sbv_reg[k] <= 1'b0;
            vq1_reg <= 1'b0;
            vq2_reg <= 1'b0;
            vq3_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= item_valid && !item.is_load;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            sbv_reg[0] <= v6_reg;
            for (int k = 1; k < QB; k++)
                sbv_reg[k] <= sbv_reg[k-1];
            vq1_reg <= sbv_reg[QB-1];
            vq2_reg <= vq1_reg;
            vq3_reg <= vq2_reg;
            out_valid_reg <= vq3_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg <= item.x;
            y1_reg <= item.y;
            z1_reg <= item.z;

            // products, floor shift by dropping fraction bits
            for (int r = 0; r < 4; r++)
            begin
                px2_reg[r] <= mx[r][63:FRAC_BITS];
                py2_reg[r] <= my[r][63:FRAC_BITS];
                pz2_reg[r] <= mz[r][63:FRAC_BITS];
                t2_reg[r]  <= mat_reg[12+r];
            end

            for (int r = 0; r < 4; r++)
            begin
                a3_reg[r] <= CW'(px2_reg[r]) + CW'(py2_reg[r]);
                b3_reg[r] <= CW'(pz2_reg[r]) + CW'(t2_reg[r]);
                c4_reg[r] <= a3_reg[r] + b3_reg[r];
            end

            // classify w, take magnitudes
            st5_reg <= st5_next;
            w5_reg  <= c4_reg[3][CW-2:0];
            for (int i = 0; i < 3; i++)
            begin
                neg5_reg[i] <= c4_reg[i][CW-1];
                mag5_reg[i] <= c4_reg[i][CW-1] ? CW'(-c4_reg[i]) : CW'(c4_reg[i]);
            end

            // integer part check against the clamp, divider seed
            st6_reg  <= st5_reg;
            neg6_reg <= neg5_reg;
            den6_reg <= w5_reg;
            for (int i = 0; i < 3; i++)
            begin
                ovf6_reg[i] <= (CW-1)'(mag5_reg[i][CW-1:SH]) >= w5_reg;
                rem6_reg[i] <= (CW-1)'(mag5_reg[i][CW-1:SH]);
                num6_reg[i] <= {mag5_reg[i][SH-1:0], {FRAC_BITS{1'b0}}};
            end

            sb_reg[0].status <= st6_reg;
            sb_reg[0].neg    <= neg6_reg;
            sb_reg[0].ovf    <= ovf6_reg;
            for (int k = 1; k < QB; k++)
            begin
                sb_reg[k].status <= sb_reg[k-1].status;
                sb_reg[k].neg    <= sb_reg[k-1].neg;
                sb_reg[k].ovf    <= sb_reg[k-1].ovf;
            end

            // clamp and sign
            sq1_reg <= sb_last.status;
            for (int i = 0; i < 3; i++)
            begin
                if (sb_last.ovf[i])
                    n1_reg[i] <= sb_last.neg[i] ? -$signed({2'b01, {QB{1'b0}}})
                                                : $signed({2'b01, {QB{1'b0}}});
                else
                    n1_reg[i] <= sb_last.neg[i] ? -$signed({2'b00, quo[i]})
                                                : $signed({2'b00, quo[i]});
            end

            sq2_reg <= sq1_reg;
            ax2_reg <= (NW+1)'(n1_reg[0]) + ONE;
            by2_reg <= ONE - (NW+1)'(n1_reg[1]);
            nz2_reg <= n1_reg[2];

            sq3_reg <= sq2_reg;
            px3_reg <= MW'($signed({1'b0, scr_width}) * ax2_reg);
            py3_reg <= MW'($signed({1'b0, scr_height}) * by2_reg);
            nz3_reg <= nz2_reg;

            out_status_reg <= sq3_reg;
            if (sq3_reg == vwts_pkg::ST_VISIBLE)
            begin
                out_x_reg <= vwts_pkg::sat32(64'(px3_reg >>> 1));
                out_y_reg <= vwts_pkg::sat32(64'(py3_reg >>> 1));
                out_z_reg <= vwts_pkg::sat32(64'(nz3_reg));
            end
            else
            begin
                out_x_reg <= '0;
                out_y_reg <= '0;
                out_z_reg <= '0;
            end
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        vwts_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk  (clk),
            .en   (en),
            .den  (den6_reg),
            .rem0 (rem6_reg[i]),
            .num  (num6_reg[i]),
            .quo  (quo[i])
        );
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_z      = out_z_reg;

endmodule

### rtl/vertex_world_to_screen_top.sv
// vertex_world_to_screen_top: perspective projection with viewport mapping.
// Depends on vwts_pkg, vwts_front, vwts_fifo, vwts_back.
//
// Usage:
//  - Slave stream (s_*) carries requests. s_tuser selects the kind: a load
//    writes one view-matrix coefficient (column major, signed fixed point) and
//    gives no result; a project request gives one result on the master stream.
//  - Master stream (m_*) carries results: m_tuser is the status (visible,
//    behind camera, zero w); screen x/y and depth are zero unless visible.
//  - Config port: cfg_we/cfg_index/cfg_data write screen width (index 0) or
//    height (index 1); write only while no request is in flight.
//  - Throughput: one request per cycle while m_tready is high (fully pipelined
//    back end: 12 multipliers, three 40-stage dividers, viewport multipliers).
//  - Path: from acceptance to m_tvalid a request passes the front register,
//    the queue, 6 transform stages, 40 divider stages, 3 viewport stages
//    and the output register.
//  - Reset clears all valid state; the matrix is undefined until loaded and
//    width/height return to 1024/768.
//  - When m_tready is low with m_tvalid high the output register holds its
//    result and the whole back pipeline freezes; the queue and front register
//    keep taking requests until they fill, after which s_tready drops.
module vertex_world_to_screen_top #(
    parameter int FRAC_BITS   = vwts_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = vwts_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // coef_index[3:0], coef_value[35:4], point_x[67:36], point_y[99:68],
    // point_z[131:100], zero pad
    input  logic [vwts_pkg::IN_DATA_W-1:0]   s_tdata,
    // command[0]
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // screen_x[31:0], screen_y[63:32], depth[95:64]
    output logic [vwts_pkg::OUT_DATA_W-1:0]  m_tdata,
    // status[1:0]
    output logic [1:0]                       m_tuser,
    input  logic                             cfg_we,
    input  logic [0:0]                       cfg_index,
    input  logic [vwts_pkg::DIM_W-1:0]       cfg_data
);

    vwts_pkg::vwts_item_t front_item;
    logic                 front_valid;
    logic                 queue_ready;
    vwts_pkg::vwts_item_t queue_item;
    logic                 queue_valid;
    logic                 queue_pop;
    logic [vwts_pkg::DIM_W-1:0] width_reg;
    logic [vwts_pkg::DIM_W-1:0] height_reg;
    logic [31:0]          res_x, res_y, res_z;

    // viewport registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= vwts_pkg::WIDTH_RESET;
            height_reg <= vwts_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index[0])
                vwts_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                vwts_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    vwts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (queue_ready)
    );

    // request queue: lets the front keep accepting while the back is stalled
    vwts_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_valid),
        .push_item  (front_item),
        .push_ready (queue_ready),
        .out_valid  (queue_valid),
        .out_item   (queue_item),
        .pop        (queue_pop)
    );

    vwts_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (queue_item),
        .item_valid (queue_valid),
        .item_pop   (queue_pop),
        .scr_width  (width_reg),
        .scr_height (height_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_x      (res_x),
        .out_y      (res_y),
        .out_z      (res_z)
    );

    assign m_tdata = {res_z, res_y, res_x};

endmodule

### rtl/vwts_checker.sv
// vwts_checker: port-level assertions for the projection block, bound to the top.
// Depends on vwts_pkg and vertex_world_to_screen_top.
module vwts_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [vwts_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]                      m_tuser
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_culled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != vwts_pkg::ST_VISIBLE |-> m_tdata == '0)
        else $error("culled point carries nonzero coordinates");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind vertex_world_to_screen_top vwts_checker u_vwts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### bench/vertex_world_to_screen_top_tb.sv
// Testbench for vertex_world_to_screen_top: loads view matrices, projects points,
// checks every result against a fixed-point projection predictor. Needs vwts_pkg.
module vertex_world_to_screen_top_tb;

    localparam int FB = vwts_pkg::FRAC_BITS_DEF;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] dz;
    } proj_res_t;

    // scoreboard: own copy of matrix and viewport, queue of pending projections
    class proj_board;
        logic signed [63:0] mtx[16];
        logic [14:0]        wid;
        logic [14:0]        hgt;
        proj_res_t          pending[$];
        int                 errors;

        function new();
            wid = vwts_pkg::WIDTH_RESET;
            hgt = vwts_pkg::HEIGHT_RESET;
            errors = 0;
            for (int i = 0; i < 16; i++)
                mtx[i] = 0;
        endfunction

        function logic signed [63:0] mul_fx(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [63:0] p;
            p = a * b;
            return p >>> FB;
        endfunction

        function logic signed [63:0] div_fx(logic signed [63:0] n, logic signed [63:0] d);
            logic [63:0]  un;
            logic [63:0]  ud;
            logic [63:0]  q;
            logic [127:0] wide;
            un = n < 0 ? -n : n;
            ud = d < 0 ? -d : d;
            if (un / ud >= (64'd1 << (vwts_pkg::QUO_BITS - FB)))
                q = 64'd1 << vwts_pkg::QUO_BITS;
            else
            begin
                wide = {64'd0, un} << FB;
                q = 64'(wide / {64'd0, ud});
            end
            if (q > (64'd1 << vwts_pkg::QUO_BITS))
                q = 64'd1 << vwts_pkg::QUO_BITS;
            return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
        endfunction

        function void note_request(logic cmd, logic [3:0] idx, logic [31:0] val,
                                   logic [31:0] px, logic [31:0] py, logic [31:0] pz);
            logic signed [63:0] x, y, z, c[4], nx, ny, nz, one, s1, s2;
            proj_res_t r;
            if (cmd == vwts_pkg::CMD_LOAD)
            begin
                mtx[idx] = $signed(val);
                return;
            end
            x = $signed(px);
            y = $signed(py);
            z = $signed(pz);
            for (int k = 0; k < 4; k++)
                c[k] = mul_fx(x, mtx[k]) + mul_fx(y, mtx[4 + k]) + mul_fx(z, mtx[8 + k])
                       + mtx[12 + k];
            r.sx = 0;
            r.sy = 0;
            r.dz = 0;
            if (c[3] < 0)
                r.status = vwts_pkg::ST_BEHIND;
            else if (c[3] == 0)
                r.status = vwts_pkg::ST_ZERO_W;
            else
            begin
                nx = div_fx(c[0], c[3]);
                ny = div_fx(c[1], c[3]);
                nz = div_fx(c[2], c[3]);
                one = 64'sd1 << FB;
                s1 = ($signed({49'd0, wid}) * (nx + one)) >>> 1;
                s2 = ($signed({49'd0, hgt}) * (one - ny)) >>> 1;
                r.status = vwts_pkg::ST_VISIBLE;
                r.sx = vwts_pkg::sat32(s1);
                r.sy = vwts_pkg::sat32(s2);
                r.dz = vwts_pkg::sat32(nz);
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [95:0] d);
            proj_res_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result status=%0d data=%h", st, d);
                return;
            end
            e = pending.pop_front();
            if (e.status !== st || e.sx !== d[31:0] || e.sy !== d[63:32] || e.dz !== d[95:64])
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp st=%0d x=%h y=%h z=%h got st=%0d x=%h y=%h z=%h",
                             e.status, e.sx, e.sy, e.dz, st, d[31:0], d[63:32], d[95:64]);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [vwts_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [vwts_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = '0;
    logic [vwts_pkg::DIM_W-1:0] cfg_data = '0;

    int src_idle_pct = 0;   // sender gap chance, percent
    int dst_idle_pct = 0;   // receiver stall chance, percent
    int hold_cycles = 0;    // long receiver hold-off
    proj_board board;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    vertex_world_to_screen_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tuser, m_tdata);
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // one request, held until accepted; gaps before it at random
    task automatic send_req(logic cmd, logic [3:0] idx, logic [31:0] val,
                            logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {4'd0, pz, py, px, val, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_request(cmd, idx, val, px, py, pz);
    endtask

    task automatic load_coef(int i, logic [31:0] v);
        send_req(vwts_pkg::CMD_LOAD, i[3:0], v, $urandom, $urandom, $urandom);
    endtask

    task automatic project(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        send_req(vwts_pkg::CMD_PROJECT, 4'($urandom), $urandom, px, py, pz);
    endtask

    // wait for all results and the pipeline to drain, ahead of a register write
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_dim(logic [0:0] idx, logic [14:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == vwts_pkg::CFG_WIDTH)
            board.wid = v;
        else
            board.hgt = v;
        @(posedge clk);
    endtask

    // plausible camera: identity-ish with w = z + offset, random perturbation
    task automatic load_camera(bit wild);
        for (int i = 0; i < 16; i++)
        begin
            logic [31:0] v;
            if (wild)
                v = $urandom;
            else
            begin
                v = $signed($urandom_range(8191)) - 4096;
                if (i == 0 || i == 5 || i == 10 || i == 11)
                    v = v + 32'h0001_0000;
                if (i == 15)
                    v = $urandom_range(32'h0010_0000);
            end
            load_coef(i, v);
        end
    endtask

    task automatic random_points(int n);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(19) == 0)
                load_coef($urandom_range(15), $urandom_range(3) == 0 ? $urandom
                          : $signed($urandom_range(32'h3_0000)) - 32'h1_8000);
            else if ($urandom_range(9) == 0)
                project($urandom, $urandom, $urandom);
            else
                project($signed($urandom_range(32'h40_0000)) - 32'h20_0000,
                        $signed($urandom_range(32'h40_0000)) - 32'h20_0000,
                        $signed($urandom_range(32'h40_0000)) - 32'h20_0000);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity matrix, then field extremes
        for (int i = 0; i < 16; i++)
            load_coef(i, (i % 5 == 0) ? 32'h0001_0000 : 32'h0);
        project(32'h0, 32'h0, 32'h0);              // w = 1: visible center
        project(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        project(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        load_coef(15, 32'h0);
        project(32'h0, 32'h0, 32'h0);              // zero w
        load_coef(15, 32'h8000_0000);
        project(32'h1234_5678, 32'h0, 32'h0);      // behind camera
        load_coef(15, 32'h7fff_ffff);
        project(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        load_coef(15, 32'h0000_0001);               // tiny w: huge quotient
        project(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
        drain();
        write_dim(vwts_pkg::CFG_WIDTH, 15'd0);     // zero dims give zero coordinates
        write_dim(vwts_pkg::CFG_HEIGHT, 15'h7fff);
        project(32'h0, 32'h0, 32'h0);
        project(32'hffff_ffff, 32'h0001_0000, 32'h0);

        // random phases across settings and idling profiles
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    write_dim(vwts_pkg::CFG_WIDTH, 15'd1);
                    write_dim(vwts_pkg::CFG_HEIGHT, 15'd1);
                end
                1:
                begin
                    write_dim(vwts_pkg::CFG_WIDTH, 15'd16384);
                    write_dim(vwts_pkg::CFG_HEIGHT, 15'd16384);
                end
                2:
                begin
                    write_dim(vwts_pkg::CFG_WIDTH, 15'd1920);
                    write_dim(vwts_pkg::CFG_HEIGHT, 15'd1080);
                end
                3:
                begin
                    write_dim(vwts_pkg::CFG_WIDTH, 15'h7fff);
                    write_dim(vwts_pkg::CFG_HEIGHT, 15'd0);
                end
                4:
                begin
                    write_dim(vwts_pkg::CFG_WIDTH, 15'($urandom));
                    write_dim(vwts_pkg::CFG_HEIGHT, 15'($urandom));
                end
                default:
                begin
                    write_dim(vwts_pkg::CFG_WIDTH, 15'd640);
                    write_dim(vwts_pkg::CFG_HEIGHT, 15'd480);
                end
            endcase
            src_idle_pct = (ph < 2) ? 32 : (ph < 4) ? 78 : 0;
            dst_idle_pct = (ph < 2) ? 78 : (ph < 4) ? 32 : 0;
            if (ph == 4)
                hold_cycles = 300;                 // back up the pipe and stall input
            load_camera(ph == 3);
            random_points(50);
        end

        drain();
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

### filelist.f
rtl/vwts_pkg.sv
rtl/vwts_front.sv
rtl/vwts_fifo.sv
rtl/vwts_div.sv
rtl/vwts_back.sv
rtl/vertex_world_to_screen_top.sv
rtl/vwts_checker.sv
bench/vertex_world_to_screen_top_tb.sv
